// ===== rtl/zbp_pkg.sv =====
// ----------------------------------------------------------------------------
// zbp_pkg
// Shared constants for the z-buffered point projector: command codes,
// configuration register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package zbp_pkg;

   localparam int DEF_SCREEN_WIDTH  = 160;
   localparam int DEF_SCREEN_HEIGHT = 44;

   localparam int COORD_W    = 16;
   localparam int GLYPH_W    = 8;
   localparam int CELL_W     = 13;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int TRIG_W     = 16;
   localparam int FOCAL_W    = 8;
   localparam int VDIST_W    = 10;
   localparam int DEPTH_W    = 16;

   localparam logic CMD_PLOT = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SIN_A       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COS_A       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_B       = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COS_B       = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_C       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COS_C       = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_SCALE = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_DIST   = 4'd7;

   localparam logic signed [TRIG_W-1:0] RST_SIN = 16'sd0;
   localparam logic signed [TRIG_W-1:0] RST_COS = 16'sd16384;
   localparam logic [FOCAL_W-1:0]       RST_FOCAL = 8'd40;
   localparam logic [VDIST_W-1:0]       RST_VDIST = 10'd100;

   localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'd32;
   localparam logic [DEPTH_W-1:0] DEPTH_FAR   = 16'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_SAT   = 16'hFFFF;

endpackage

// ===== rtl/zbp_if.sv =====
// ----------------------------------------------------------------------------
// zbp_if
// Valid/ready channels of the z-buffered point projector: request beats,
// response beats and configuration register writes.
// ----------------------------------------------------------------------------
interface zbp_req_if;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] point_z;
   logic [7:0]        glyph;
   logic [12:0]       read_cell;

   modport source(output valid, cmd, point_x, point_y, point_z, glyph, read_cell,
                  input ready);
   modport sink(input valid, cmd, point_x, point_y, point_z, glyph, read_cell,
                output ready);
endinterface

interface zbp_rsp_if;
   logic        valid;
   logic        ready;
   logic        drawn;
   logic [12:0] cell_index;
   logic [7:0]  glyph_out;

   modport source(output valid, drawn, cell_index, glyph_out, input ready);
   modport sink(input valid, drawn, cell_index, glyph_out, output ready);
endinterface

interface zbp_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/zbuffered_point_projector.sv =====
// ----------------------------------------------------------------------------
// zbuffered_point_projector
// Rotates Q8.8 points, projects them in perspective and keeps the nearest
// glyph of each screen cell in an on-chip depth buffer.
//
// A request beat either plots a point (cmd plot) or reads and clears one
// screen cell (cmd read). Every request beat yields exactly one response beat.
// Configuration writes on the csr channel set the sine/cosine registers, the
// focal scale and the view distance; the user must see that they are only
// issued while idle, which the block itself does not enforce. After a write
// the rotation coefficients are rebuilt, during which req_ch.ready stays low.
// A plot passes nine rotation products and the column and row products
// through one 34x26 multiplier, which the coefficient rebuild also uses, and
// the inverse depth comes from a 16-step restoring divider. When the depth is
// so near that the inverse depth saturates, the divider is skipped; a point at
// or behind the viewer is not projected and not drawn.
// Reads and plots whose cell is in range end with a read-modify-write of the
// cell memory.
// After reset the cell memory is swept to spaces and zero depth, one cell
// per cycle (SCREEN_WIDTH*SCREEN_HEIGHT cells, 7040 at the defaults),
// followed by the coefficient build; no request is taken until then.
// The response sits in an output register; a new request is accepted while it
// waits, and a stalled receiver holds the block only when the next response
// is ready to be loaded.
// ----------------------------------------------------------------------------
module zbuffered_point_projector import zbp_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input logic     clock,
   input logic     reset,
   zbp_req_if.sink   req_ch,
   zbp_rsp_if.source rsp_ch,
   zbp_csr_if.sink   csr_ch
);

   localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int IDX_W = 46;
   localparam int MEM_W = GLYPH_W + DEPTH_W;

   localparam logic [AW-1:0]          CLR_LAST = AW'(CELLS - 1);
   localparam logic signed [IDX_W-1:0] CELLS_S = IDX_W'(CELLS);
   localparam logic signed [IDX_W-1:0] WIDTH_S = IDX_W'(SCREEN_WIDTH);
   localparam logic signed [61:0] COL_BIAS = 62'(SCREEN_WIDTH / 2) <<< 32;
   localparam logic signed [61:0] ROW_BIAS = 62'(SCREEN_HEIGHT / 2) <<< 32;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_COEF  = 4'd2;
   localparam logic [3:0] ST_ROT   = 4'd3;
   localparam logic [3:0] ST_ZCHK  = 4'd4;
   localparam logic [3:0] ST_DIV   = 4'd5;
   localparam logic [3:0] ST_PROJ  = 4'd6;
   localparam logic [3:0] ST_IDX   = 4'd7;
   localparam logic [3:0] ST_RD    = 4'd8;
   localparam logic [3:0] ST_CMP   = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   localparam logic [3:0] COEF_LAST = 4'd13;
   localparam logic [3:0] ROT_LAST  = 4'd8;
   localparam logic [3:0] DIV_LAST  = 4'd15;
   localparam logic [3:0] PROJ_FS   = 4'd0;
   localparam logic [3:0] PROJ_COL  = 4'd1;
   localparam logic [3:0] PROJ_ROW  = 4'd2;

   function automatic logic signed [33:0] trunc32(input logic signed [61:0] v);
      logic [61:0] mag;
      logic [61:0] q;
      mag = v[61] ? 62'(-v) : 62'(v);
      q = mag >> 32;
      trunc32 = v[61] ? -34'(q) : 34'(q);
   endfunction

   // Configuration registers.
   logic signed [TRIG_W-1:0] sin_a_ff, cos_a_ff, sin_b_ff, cos_b_ff, sin_c_ff, cos_c_ff;
   logic [FOCAL_W-1:0]       focal_ff;
   logic [VDIST_W-1:0]       vdist_ff;

   // Control.
   logic [3:0]    state_ff, state_in;
   logic [3:0]    step_ff, step_in;
   logic          dirty_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          req_fire, csr_fire;

   // Shared multiplier.
   logic signed [33:0] mul_a;
   logic signed [25:0] mul_b;
   logic               iss;
   logic signed [59:0] prod_ff;
   logic               wb_valid_ff;
   logic [3:0]         wb_step_ff;

   // Coefficients and partial products.
   logic signed [31:0] p1_ff, p2_ff, cacs_ff, sasc_ff, cacc_ff, sacc_ff;
   logic signed [33:0] cxi_ff, cxj_ff, cxk_ff, cyi_ff, cyj_ff, cyk_ff;
   logic signed [33:0] czi_ff, czj_ff, czk_ff;
   logic signed [33:0] tri_w;

   // Item datapath.
   logic               read_ff;
   logic signed [15:0] px_ff, py_ff, pz_ff;
   logic [GLYPH_W-1:0] glyph_ff;
   logic signed [51:0] acc_x_ff, acc_y_ff, acc_z_ff;
   logic signed [31:0] rx_w, ry_w, rz_w;
   logic signed [33:0] zt_w;
   logic [33:0]        zt_ff;
   logic [33:0]        rem_ff;
   logic [33:0]        rem2_w;
   logic               zt_pos, zt_sat;
   logic [DEPTH_W-1:0] invz_ff;
   logic [23:0]        fsinv_ff;
   logic signed [33:0] col_ff, row_ff;
   logic signed [IDX_W-1:0] idx_ff;
   logic               in_range;

   // Cell memory: glyph in the upper byte, inverse depth below.
   logic [MEM_W-1:0] cell_mem [CELLS];
   logic [MEM_W-1:0] rd_data_ff;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [MEM_W-1:0] wr_data;
   logic             wr_en;

   // Result staging and output register.
   logic               res_drawn_ff;
   logic [CELL_W-1:0]  res_cell_ff;
   logic [GLYPH_W-1:0] res_glyph_ff;
   logic               rsp_valid_ff;
   logic               rsp_drawn_ff;
   logic [CELL_W-1:0]  rsp_cell_ff;
   logic [GLYPH_W-1:0] rsp_glyph_ff;
   logic               rsp_load;

   assign req_ch.ready = (state_ff == ST_IDLE) && !dirty_ff;
   assign csr_ch.ready = 1'b1;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.drawn      = rsp_drawn_ff;
   assign rsp_ch.cell_index = rsp_cell_ff;
   assign rsp_ch.glyph_out  = rsp_glyph_ff;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rx_w = acc_x_ff[51:20];
   assign ry_w = acc_y_ff[51:20];
   assign rz_w = acc_z_ff[51:20];
   assign zt_w = 34'(rz_w) + $signed({8'b0, vdist_ff, 16'b0});
   assign zt_pos = (zt_w > 34'sd0);
   assign zt_sat = (zt_w <= 34'sd65536);
   assign rem2_w = {rem_ff[32:0], 1'b0};
   assign tri_w = $signed(prod_ff[47:14]);
   assign in_range = !idx_ff[IDX_W-1] && (idx_ff < CELLS_S);

   assign rd_addr = idx_ff[AW-1:0];

   always_comb begin
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = {GLYPH_SPACE, DEPTH_FAR};
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_addr_ff;
      end else if (state_ff == ST_CMP) begin
         if (read_ff) begin
            wr_en = 1'b1;
         end else if (invz_ff > rd_data_ff[DEPTH_W-1:0]) begin
            wr_en = 1'b1;
            wr_data = {glyph_ff, invz_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= cell_mem[rd_addr];
   end

   // Multiplier operand selection.
   always_comb begin
      iss = 1'b0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_COEF: begin
            iss = (step_ff <= COEF_LAST);
            unique case (step_ff)
               4'd0: begin mul_a = 34'(sin_a_ff); mul_b = 26'(sin_b_ff); end
               4'd1: begin mul_a = 34'(cos_a_ff); mul_b = 26'(sin_b_ff); end
               4'd2: begin mul_a = 34'(cos_b_ff); mul_b = 26'(cos_c_ff); end
               4'd3: begin mul_a = 34'(cos_a_ff); mul_b = 26'(sin_c_ff); end
               4'd4: begin mul_a = 34'(sin_a_ff); mul_b = 26'(sin_c_ff); end
               4'd5: begin mul_a = 34'(cos_b_ff); mul_b = 26'(sin_c_ff); end
               4'd6: begin mul_a = 34'(cos_a_ff); mul_b = 26'(cos_c_ff); end
               4'd7: begin mul_a = 34'(sin_a_ff); mul_b = 26'(cos_c_ff); end
               4'd8: begin mul_a = 34'(sin_a_ff); mul_b = 26'(cos_b_ff); end
               4'd9: begin mul_a = 34'(cos_a_ff); mul_b = 26'(cos_b_ff); end
               4'd10: begin mul_a = 34'(p1_ff); mul_b = 26'(cos_c_ff); end
               4'd11: begin mul_a = 34'(p2_ff); mul_b = 26'(cos_c_ff); end
               4'd12: begin mul_a = 34'(p1_ff); mul_b = 26'(sin_c_ff); end
               4'd13: begin mul_a = 34'(p2_ff); mul_b = 26'(sin_c_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_ROT: begin
            iss = (step_ff <= ROT_LAST);
            unique case (step_ff)
               4'd0: begin mul_a = cxi_ff; mul_b = 26'(px_ff); end
               4'd1: begin mul_a = cxj_ff; mul_b = 26'(py_ff); end
               4'd2: begin mul_a = cxk_ff; mul_b = 26'(pz_ff); end
               4'd3: begin mul_a = cyi_ff; mul_b = 26'(px_ff); end
               4'd4: begin mul_a = cyj_ff; mul_b = 26'(py_ff); end
               4'd5: begin mul_a = cyk_ff; mul_b = 26'(pz_ff); end
               4'd6: begin mul_a = czi_ff; mul_b = 26'(px_ff); end
               4'd7: begin mul_a = czj_ff; mul_b = 26'(py_ff); end
               4'd8: begin mul_a = czk_ff; mul_b = 26'(pz_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_PROJ: begin
            if (step_ff == PROJ_COL) begin
               iss = 1'b1;
               mul_a = 34'(rx_w);
               mul_b = $signed({1'b0, fsinv_ff, 1'b0});
            end else if (step_ff == PROJ_ROW) begin
               iss = 1'b1;
               mul_a = 34'(ry_w);
               mul_b = $signed({2'b0, fsinv_ff});
            end
         end
         default: begin
            iss = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (dirty_ff) begin
               state_in = ST_COEF;
               step_in = '0;
            end else if (req_fire) begin
               step_in = '0;
               state_in = (req_ch.cmd == CMD_READ) ? ST_RD : ST_ROT;
            end
         end
         ST_COEF: begin
            if (step_ff <= COEF_LAST) step_in = step_ff + 4'd1;
            if (wb_valid_ff && wb_step_ff == COEF_LAST) state_in = ST_IDLE;
         end
         ST_ROT: begin
            if (step_ff <= ROT_LAST) step_in = step_ff + 4'd1;
            if (wb_valid_ff && wb_step_ff == ROT_LAST) state_in = ST_ZCHK;
         end
         ST_ZCHK: begin
            step_in = '0;
            if (!zt_pos) state_in = ST_DONE;
            else if (zt_sat) state_in = ST_PROJ;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == DIV_LAST) begin
               state_in = ST_PROJ;
               step_in = '0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_PROJ: begin
            if (step_ff <= PROJ_ROW) step_in = step_ff + 4'd1;
            if (wb_valid_ff && wb_step_ff == PROJ_ROW) state_in = ST_IDX;
         end
         ST_IDX: state_in = ST_RD;
         ST_RD: state_in = in_range ? ST_CMP : ST_DONE;
         ST_CMP: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff <= '0;
         dirty_ff <= 1'b1;
         clr_addr_ff <= '0;
         wb_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sin_a_ff <= RST_SIN;
         cos_a_ff <= RST_COS;
         sin_b_ff <= RST_SIN;
         cos_b_ff <= RST_COS;
         sin_c_ff <= RST_SIN;
         cos_c_ff <= RST_COS;
         focal_ff <= RST_FOCAL;
         vdist_ff <= RST_VDIST;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         wb_valid_ff <= iss;
         if (state_ff == ST_CLEAR) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (csr_fire) dirty_ff <= 1'b1;
         else if (state_ff == ST_IDLE) dirty_ff <= 1'b0;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         if (csr_fire) begin
            unique case (csr_ch.index)
               REG_SIN_A: sin_a_ff <= $signed(csr_ch.data);
               REG_COS_A: cos_a_ff <= $signed(csr_ch.data);
               REG_SIN_B: sin_b_ff <= $signed(csr_ch.data);
               REG_COS_B: cos_b_ff <= $signed(csr_ch.data);
               REG_SIN_C: sin_c_ff <= $signed(csr_ch.data);
               REG_COS_C: cos_c_ff <= $signed(csr_ch.data);
               REG_FOCAL_SCALE: focal_ff <= csr_ch.data[FOCAL_W-1:0];
               REG_VIEW_DIST: vdist_ff <= csr_ch.data[VDIST_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      wb_step_ff <= step_ff;

      if (rsp_load) begin
         rsp_drawn_ff <= res_drawn_ff;
         rsp_cell_ff <= res_cell_ff;
         rsp_glyph_ff <= res_glyph_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            czi_ff <= $signed({{4{sin_b_ff[15]}}, sin_b_ff, 14'b0});
            read_ff <= (req_ch.cmd == CMD_READ);
            px_ff <= req_ch.point_x;
            py_ff <= req_ch.point_y;
            pz_ff <= req_ch.point_z;
            glyph_ff <= req_ch.glyph;
            idx_ff <= IDX_W'(req_ch.read_cell);
            acc_x_ff <= '0;
            acc_y_ff <= '0;
            acc_z_ff <= '0;
         end
         ST_COEF: begin
            if (wb_valid_ff) begin
               unique case (wb_step_ff)
                  4'd0: p1_ff <= $signed(prod_ff[31:0]);
                  4'd1: p2_ff <= $signed(prod_ff[31:0]);
                  4'd2: cxi_ff <= 34'($signed(prod_ff[31:0]));
                  4'd3: cacs_ff <= $signed(prod_ff[31:0]);
                  4'd4: sasc_ff <= $signed(prod_ff[31:0]);
                  4'd5: cyi_ff <= -34'($signed(prod_ff[31:0]));
                  4'd6: cacc_ff <= $signed(prod_ff[31:0]);
                  4'd7: sacc_ff <= $signed(prod_ff[31:0]);
                  4'd8: czj_ff <= -34'($signed(prod_ff[31:0]));
                  4'd9: czk_ff <= 34'($signed(prod_ff[31:0]));
                  4'd10: cxj_ff <= tri_w + 34'(cacs_ff);
                  4'd11: cxk_ff <= 34'(sasc_ff) - tri_w;
                  4'd12: cyj_ff <= 34'(cacc_ff) - tri_w;
                  4'd13: cyk_ff <= 34'(sacc_ff) + tri_w;
                  default: ;
               endcase
            end
         end
         ST_ROT: begin
            if (wb_valid_ff) begin
               if (wb_step_ff <= 4'd2) acc_x_ff <= acc_x_ff + $signed(prod_ff[51:0]);
               else if (wb_step_ff <= 4'd5) acc_y_ff <= acc_y_ff + $signed(prod_ff[51:0]);
               else acc_z_ff <= acc_z_ff + $signed(prod_ff[51:0]);
            end
         end
         ST_ZCHK: begin
            zt_ff <= zt_w;
            rem_ff <= 34'd65536;
            invz_ff <= DEPTH_SAT;
            res_drawn_ff <= 1'b0;
            res_cell_ff <= '0;
            res_glyph_ff <= '0;
         end
         ST_DIV: begin
            if (rem2_w >= zt_ff) begin
               rem_ff <= rem2_w - zt_ff;
               invz_ff <= {invz_ff[DEPTH_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem2_w;
               invz_ff <= {invz_ff[DEPTH_W-2:0], 1'b0};
            end
         end
         ST_PROJ: begin
            if (step_ff == PROJ_FS) fsinv_ff <= focal_ff * invz_ff;
            if (wb_valid_ff && wb_step_ff == PROJ_COL) begin
               col_ff <= trunc32(62'(prod_ff) + COL_BIAS);
            end
            if (wb_valid_ff && wb_step_ff == PROJ_ROW) begin
               row_ff <= trunc32(62'(prod_ff) + ROW_BIAS);
            end
         end
         ST_IDX: begin
            idx_ff <= IDX_W'(col_ff) + IDX_W'(row_ff) * WIDTH_S;
         end
         ST_RD: begin
            res_drawn_ff <= 1'b0;
            if (read_ff) begin
               res_cell_ff <= idx_ff[CELL_W-1:0];
               res_glyph_ff <= GLYPH_SPACE;
            end else begin
               res_cell_ff <= '0;
               res_glyph_ff <= '0;
            end
         end
         ST_CMP: begin
            res_cell_ff <= idx_ff[CELL_W-1:0];
            if (read_ff) begin
               res_drawn_ff <= 1'b0;
               res_glyph_ff <= rd_data_ff[MEM_W-1:DEPTH_W];
            end else begin
               res_drawn_ff <= (invz_ff > rd_data_ff[DEPTH_W-1:0]);
               res_glyph_ff <= '0;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== sim/zbp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zbp_checker
// Watches the request, response and register write channels of the projector.
// It keeps its own copy of the registers and of the glyph and depth buffers,
// predicts one response per accepted request beat, and compares each response
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module zbp_checker import zbp_pkg::*; (
   input  logic clock,
   input  logic reset,
   zbp_req_if   req,
   zbp_rsp_if   rsp,
   zbp_csr_if   csr,
   output int   fail_count,
   output int   outstanding
);

   localparam int CELLS = DEF_SCREEN_WIDTH * DEF_SCREEN_HEIGHT;

   typedef struct packed {
      logic              drawn;
      logic [CELL_W-1:0] cell_index;
      logic [GLYPH_W-1:0] glyph_out;
   } cell_beat_type;

   cell_beat_type predicted_q[$];
   longint sin_a, cos_a, sin_b, cos_b, sin_c, cos_c, focal, vdist;
   logic [GLYPH_W-1:0] glyph_buf [CELLS];
   logic [DEPTH_W-1:0] depth_buf [CELLS];

   function automatic longint trunc32(input longint v);
      if (v >= 0) return v >>> 32;
      return -((-v) >>> 32);
   endfunction

   function automatic cell_beat_type project_point(input logic signed [COORD_W-1:0] px,
                                                   input logic signed [COORD_W-1:0] py,
                                                   input logic signed [COORD_W-1:0] pz,
                                                   input logic [GLYPH_W-1:0] g);
      cell_beat_type b;
      longint xi, xj, xk, yi, yj, yk, zi, zj, zk;
      longint rx, ry, rz, zt, invz, col, row, idx;
      b = '0;
      xi = cos_b * cos_c;
      xj = ((sin_a * sin_b * cos_c) >>> 14) + cos_a * sin_c;
      xk = -((cos_a * sin_b * cos_c) >>> 14) + sin_a * sin_c;
      yi = -(cos_b * sin_c);
      yj = cos_a * cos_c - ((sin_a * sin_b * sin_c) >>> 14);
      yk = sin_a * cos_c + ((cos_a * sin_b * sin_c) >>> 14);
      zi = sin_b * 16384;
      zj = -(sin_a * cos_b);
      zk = cos_a * cos_b;
      rx = (longint'(px) * xi + longint'(py) * xj + longint'(pz) * xk) >>> 20;
      ry = (longint'(px) * yi + longint'(py) * yj + longint'(pz) * yk) >>> 20;
      rz = (longint'(px) * zi + longint'(py) * zj + longint'(pz) * zk) >>> 20;
      zt = rz + vdist * 65536;
      if (zt <= 0) return b;
      invz = (64'sd1 <<< 32) / zt;
      if (invz > 65535) invz = 65535;
      col = trunc32((longint'(DEF_SCREEN_WIDTH / 2) <<< 32) + 2 * focal * rx * invz);
      row = trunc32((longint'(DEF_SCREEN_HEIGHT / 2) <<< 32) + focal * ry * invz);
      idx = col + row * DEF_SCREEN_WIDTH;
      if (idx < 0 || idx >= CELLS) return b;
      b.cell_index = idx[CELL_W-1:0];
      if (invz[DEPTH_W-1:0] > depth_buf[idx]) begin
         depth_buf[idx] = invz[DEPTH_W-1:0];
         glyph_buf[idx] = g;
         b.drawn = 1'b1;
      end
      return b;
   endfunction

   function automatic cell_beat_type read_clear(input logic [CELL_W-1:0] cell_no);
      cell_beat_type b;
      b = '0;
      b.cell_index = cell_no;
      if (cell_no < CELLS) begin
         b.glyph_out = glyph_buf[cell_no];
         glyph_buf[cell_no] = GLYPH_SPACE;
         depth_buf[cell_no] = DEPTH_FAR;
      end else begin
         b.glyph_out = GLYPH_SPACE;
      end
      return b;
   endfunction

   always @(posedge clock) begin
      cell_beat_type want;
      if (reset) begin
         sin_a = RST_SIN; cos_a = RST_COS;
         sin_b = RST_SIN; cos_b = RST_COS;
         sin_c = RST_SIN; cos_c = RST_COS;
         focal = RST_FOCAL;
         vdist = RST_VDIST;
         for (int i = 0; i < CELLS; i++) begin
            glyph_buf[i] = GLYPH_SPACE;
            depth_buf[i] = DEPTH_FAR;
         end
         predicted_q.delete();
         fail_count <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_SIN_A:       sin_a = longint'($signed(csr.data));
               REG_COS_A:       cos_a = longint'($signed(csr.data));
               REG_SIN_B:       sin_b = longint'($signed(csr.data));
               REG_COS_B:       cos_b = longint'($signed(csr.data));
               REG_SIN_C:       sin_c = longint'($signed(csr.data));
               REG_COS_C:       cos_c = longint'($signed(csr.data));
               REG_FOCAL_SCALE: focal = csr.data[FOCAL_W-1:0];
               REG_VIEW_DIST:   vdist = csr.data[VDIST_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (predicted_q.size() == 0) begin
               $error("Response beat with no request waiting: cell_index %0d",
                      rsp.cell_index);
               fail_count <= fail_count + 1;
            end else begin
               want = predicted_q.pop_front();
               if (rsp.drawn !== want.drawn ||
                   rsp.cell_index !== want.cell_index ||
                   rsp.glyph_out !== want.glyph_out) begin
                  fail_count <= fail_count + 1;
                  if (rsp.drawn !== want.drawn)
                     $error("drawn expected %0d actual %0d", want.drawn, rsp.drawn);
                  if (rsp.cell_index !== want.cell_index)
                     $error("cell_index expected %0d actual %0d",
                            want.cell_index, rsp.cell_index);
                  if (rsp.glyph_out !== want.glyph_out)
                     $error("glyph_out expected %0d actual %0d",
                            want.glyph_out, rsp.glyph_out);
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.cmd == CMD_READ)
               predicted_q.push_back(read_clear(req.read_cell));
            else
               predicted_q.push_back(project_point(req.point_x, req.point_y,
                                                   req.point_z, req.glyph));
         end
      end
      outstanding <= predicted_q.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the z-buffered point projector. Directed plots and reads come
// first, then random bursts under several register settings, with a stalling
// receiver. The checker instance predicts and compares every response beat.
// ----------------------------------------------------------------------------
module tb;
   import zbp_pkg::*;

   localparam int LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   outstanding;
   int   cycles = 0;
   int   burst_left = 0;
   int   hold_asked = 0;
   int   hold_done = 0;

   zbp_req_if req_i();
   zbp_rsp_if rsp_i();
   zbp_csr_if csr_i();

   zbuffered_point_projector u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_i),
      .rsp_ch(rsp_i),
      .csr_ch(csr_i)
   );

   zbp_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_i),
      .rsp        (rsp_i),
      .csr        (csr_i),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   always #6 clock = ~clock;

   task automatic send_beat(input logic c, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z,
                            input logic [7:0] g, input logic [12:0] rc);
      req_i.valid     <= 1'b1;
      req_i.cmd       <= c;
      req_i.point_x   <= x;
      req_i.point_y   <= y;
      req_i.point_z   <= z;
      req_i.glyph     <= g;
      req_i.read_cell <= rc;
      do @(posedge clock); while (!req_i.ready);
   endtask

   task automatic plot(input int x, input int y, input int z, input int g);
      send_beat(CMD_PLOT, 16'(x), 16'(y), 16'(z), 8'(g), 13'($urandom));
   endtask

   task automatic read_cell(input int cell_no);
      send_beat(CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                13'(cell_no));
   endtask

   task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
      csr_i.valid <= 1'b1;
      csr_i.index <= idx;
      csr_i.data  <= data;
      do @(posedge clock); while (!csr_i.ready);
      csr_i.valid <= 1'b0;
   endtask

   task automatic drain;
      req_i.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_view(input int sa, input int ca, input int sb, input int cb,
                           input int sc, input int cc, input int f, input int vd);
      write_reg(REG_SIN_A, 16'(sa));
      write_reg(REG_COS_A, 16'(ca));
      write_reg(REG_SIN_B, 16'(sb));
      write_reg(REG_COS_B, 16'(cb));
      write_reg(REG_SIN_C, 16'(sc));
      write_reg(REG_COS_C, 16'(cc));
      write_reg(REG_FOCAL_SCALE, 16'(f));
      write_reg(REG_VIEW_DIST, 16'(vd));
   endtask

   function automatic int near_coord();
      return $signed($urandom_range(0, 24000)) - 12000;
   endfunction

   task automatic random_beat;
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 3)
         read_cell($urandom_range(40, 120) + 160 * $urandom_range(8, 36));
      else if (pick == 3)
         read_cell($urandom_range(0, 8191));
      else if (pick < 13)
         plot(near_coord(), near_coord(), near_coord(), $urandom);
      else
         plot($urandom, $urandom, $urandom, $urandom);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_i.valid <= 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
   endtask

   initial begin
      int mode;
      rsp_i.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         for (int i = 0; i < 200; i++) begin
            @(posedge clock);
            if (hold_asked != hold_done) begin
               rsp_i.ready <= 1'b0;
               repeat (600) @(posedge clock);
               hold_done++;
            end
            case (mode)
               0: rsp_i.ready <= 1'b1;
               1: rsp_i.ready <= $urandom_range(0, 1);
               2: rsp_i.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_i.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      req_i.valid <= 1'b0;
      req_i.cmd <= CMD_PLOT;
      req_i.point_x <= '0;
      req_i.point_y <= '0;
      req_i.point_z <= '0;
      req_i.glyph <= '0;
      req_i.read_cell <= '0;
      csr_i.valid <= 1'b0;
      csr_i.index <= '0;
      csr_i.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      plot(0, 0, 0, 8'h41);
      plot(0, 0, 256, 8'h42);
      plot(0, 0, -256, 8'hFF);
      plot(0, 0, 0, 8'h00);
      read_cell(22 * 160 + 80);
      read_cell(22 * 160 + 80);
      plot(32767, 32767, 32767, 8'h55);
      plot(-32768, -32768, -32768, 8'hAA);
      plot(0, 0, -32768, 8'h01);
      plot(0, 0, 32767, 8'h02);
      plot(32767, 0, 0, 8'h03);
      plot(-32768, 0, 0, 8'h04);
      plot(0, 32767, 0, 8'h05);
      plot(0, -32768, 0, 8'h06);
      plot(-20000, -5000, 0, 8'h07);
      plot(25000, 0, 0, 8'h08);
      read_cell(0);
      read_cell(7039);
      read_cell(7040);
      read_cell(8191);
      read_cell(22 * 160 + 80);
      drain();

      hold_asked++;
      for (int i = 0; i < 380; i++) random_beat();
      drain();

      set_view(-16384, -16384, 16384, -16384, 16384, 16384, 255, 1);
      for (int i = 0; i < 380; i++) random_beat();
      drain();

      set_view(16384, 16384, -16384, 16384, -16384, -16384, 0, 1023);
      for (int i = 0; i < 380; i++) random_beat();
      drain();

      set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(0, 255), $urandom_range(1, 1023));
      hold_asked++;
      for (int i = 0; i < 380; i++) random_beat();
      drain();

      set_view(11585, 11585, -6270, 15137, 8192, 14189, 40, 100);
      for (int i = 0; i < 380; i++) random_beat();
      drain();

      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
